FILE: src/gmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmd_pkg
// Shared types and constants of the grid distance map block.
// ----------------------------------------------------------------------------
package gmd_pkg;

    localparam int GRID_MAX_DEF = 8;

    localparam int CHAR_W = 8;
    localparam int DIST_W = 4;
    localparam int SIDE_W = 4;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CHAR_W-1:0] SOURCE_CHAR = 8'd48;
    localparam logic [DIST_W-1:0] FAR_AWAY    = 4'd15;
    localparam logic [DIST_W-1:0] DIST_MAX    = 4'd14;
    localparam logic [SIDE_W-1:0] SIDE_RESET  = 4'd8;

    // register index, taken from the upper address bit
    localparam logic REG_GRID_SIDE = 1'b0;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FILL,
        ST_SWEEP,
        ST_DRAIN
    } gmd_state_t;

    typedef struct packed {
        logic fill;
        logic shift;
    } gmd_cell_ctl_t;

endpackage
`default_nettype wire

FILE: src/gmd_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmd_ifs
// Valid/ready channels for grid cell items and distance result items.
// ----------------------------------------------------------------------------
interface gmd_grid_if import gmd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cell_char;

    modport source (output valid, output cell_char, input ready);
    modport sink   (input valid, input cell_char, output ready);
endinterface

interface gmd_result_if import gmd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              no_source;
    logic              last_cell;

    modport source (output valid, output distance, output no_source, output last_cell,
                     input ready);
    modport sink   (input valid, input distance, input no_source, input last_cell,
                    output ready);
endinterface
`default_nettype wire

FILE: src/gmd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmd_cell
// One target cell: holds its coordinates and best distance, checks each
// passing source item and hands it on to the next cell.
// ----------------------------------------------------------------------------
module gmd_cell import gmd_pkg::*; #(
    parameter int CW = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gmd_cell_ctl_t     ctl,
    input  wire logic [CW-1:0]     coord_row_in,
    input  wire logic [CW-1:0]     coord_col_in,
    output logic [CW-1:0]          coord_row_out,
    output logic [CW-1:0]          coord_col_out,
    input  wire logic              bus_valid_in,
    input  wire logic [CW-1:0]     bus_row_in,
    input  wire logic [CW-1:0]     bus_col_in,
    output logic                   bus_valid_out,
    output logic [CW-1:0]          bus_row_out,
    output logic [CW-1:0]          bus_col_out,
    input  wire logic [DIST_W-1:0] best_in,
    output logic [DIST_W-1:0]      best_out
);

    logic [CW-1:0]     row_reg;
    logic [CW-1:0]     col_reg;
    logic [DIST_W-1:0] best_reg;
    logic              bus_valid_reg;
    logic [CW-1:0]     bus_row_reg;
    logic [CW-1:0]     bus_col_reg;

    logic [CW-1:0]     row_gap;
    logic [CW-1:0]     col_gap;
    logic [DIST_W-1:0] gap_sum;

    always_comb
    begin
        row_gap = (row_reg >= bus_row_in) ? row_reg - bus_row_in : bus_row_in - row_reg;
        col_gap = (col_reg >= bus_col_in) ? col_reg - bus_col_in : bus_col_in - col_reg;
        gap_sum = DIST_W'(row_gap) + DIST_W'(col_gap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_valid_reg <= 1'b0;
        end
        else
        begin
            bus_valid_reg <= bus_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        bus_row_reg <= bus_row_in;
        bus_col_reg <= bus_col_in;
        if (ctl.fill)
        begin
            row_reg  <= coord_row_in;
            col_reg  <= coord_col_in;
            best_reg <= FAR_AWAY;
        end
        else if (ctl.shift)
        begin
            best_reg <= best_in;
        end
        else if (bus_valid_in && (gap_sum < best_reg))
        begin
            best_reg <= gap_sum;
        end
    end

    assign coord_row_out = row_reg;
    assign coord_col_out = col_reg;
    assign bus_valid_out = bus_valid_reg;
    assign bus_row_out   = bus_row_reg;
    assign bus_col_out   = bus_col_reg;
    assign best_out      = best_reg;

endmodule
`default_nettype wire

FILE: src/gmd_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmd_seq
// Loads the source map, runs the fill, sweep and drain passes of the cell
// chain and registers the result items.
// ----------------------------------------------------------------------------
module gmd_seq import gmd_pkg::*; #(
    parameter int GRID_MAX = GRID_MAX_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic [SIDE_W-1:0]                      grid_side,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [CHAR_W-1:0]                      cell_char,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [DIST_W-1:0]                           distance,
    output logic                                        no_source,
    output logic                                        last_cell,
    output gmd_cell_ctl_t                               cell_ctl,
    output logic [$clog2(GRID_MAX)-1:0]                 inj_row,
    output logic [$clog2(GRID_MAX)-1:0]                 inj_col,
    output logic                                        bus_valid,
    output logic [$clog2(GRID_MAX)-1:0]                 bus_row,
    output logic [$clog2(GRID_MAX)-1:0]                 bus_col,
    input  wire logic [DIST_W-1:0]                      tail_best
);

    localparam int CELLS = GRID_MAX * GRID_MAX;
    localparam int CW    = $clog2(GRID_MAX);
    localparam int IDXW  = $clog2(CELLS);
    localparam int LCW   = $clog2(CELLS + 1);
    localparam int CNTW  = $clog2(2 * CELLS);

    gmd_state_t        state_reg, state_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [LCW-1:0]    load_cnt_reg, load_cnt_next;
    logic              any_src_reg, any_src_next;
    logic [SIDE_W-1:0] side_run_reg, side_run_next;
    logic [LCW-1:0]    n_run_reg, n_run_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_src_reg;
    logic [CW-1:0]     rd_row_reg;
    logic [CW-1:0]     rd_col_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] distance_reg, distance_next;
    logic              no_source_reg, no_source_next;
    logic              last_cell_reg, last_cell_next;

    logic              src_mem [CELLS];

    logic [SIDE_W-1:0] side_use;
    logic [LCW-1:0]    n_use;
    logic [LCW-1:0]    load_inc;
    logic              accept;
    logic              is_src;
    logic              out_free;
    logic              col_wrap;
    logic [CW-1:0]     col_adv;
    logic [CW-1:0]     row_adv;
    logic              out_load;

    always_comb
    begin
        if (grid_side == '0)
        begin
            side_use = SIDE_W'(1);
        end
        else if (grid_side > SIDE_W'(GRID_MAX))
        begin
            side_use = SIDE_W'(GRID_MAX);
        end
        else
        begin
            side_use = grid_side;
        end
        n_use    = LCW'(side_use) * LCW'(side_use);
        load_inc = load_cnt_reg + LCW'(1);
        in_ready = (state_reg == ST_LOAD);
        accept   = in_valid && in_ready;
        is_src   = (cell_char == SOURCE_CHAR);
        out_free = !out_valid_reg || out_ready;
        col_wrap = (col_reg == CW'(side_run_reg - SIDE_W'(1)));
        col_adv  = col_wrap ? '0 : col_reg + CW'(1);
        row_adv  = col_wrap ? row_reg + CW'(1) : row_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        load_cnt_next  = load_cnt_reg;
        any_src_next   = any_src_reg;
        side_run_next  = side_run_reg;
        n_run_next     = n_run_reg;
        rd_valid_next  = 1'b0;
        out_load       = 1'b0;
        cell_ctl.fill  = 1'b0;
        cell_ctl.shift = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    load_cnt_next = load_inc;
                    any_src_next  = any_src_reg || is_src;
                    if (load_inc >= n_use)
                    begin
                        load_cnt_next = '0;
                        side_run_next = side_use;
                        n_run_next    = n_use;
                        cnt_next      = '0;
                        row_next      = '0;
                        col_next      = '0;
                        state_next    = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                cell_ctl.fill = 1'b1;
                row_next      = row_adv;
                col_next      = col_adv;
                cnt_next      = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                rd_valid_next = (cnt_reg < CNTW'(n_run_reg));
                row_next      = row_adv;
                col_next      = col_adv;
                cnt_next      = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(n_run_reg) + CNTW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    cell_ctl.shift = 1'b1;
                    cnt_next       = cnt_reg + CNTW'(1);
                    if (cnt_reg == CNTW'(n_run_reg - LCW'(1)))
                    begin
                        any_src_next = 1'b0;
                        state_next   = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        out_valid_next = out_valid_reg && !out_ready;
        distance_next  = distance_reg;
        no_source_next = no_source_reg;
        last_cell_next = last_cell_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            distance_next  = any_src_reg ? tail_best : '0;
            no_source_next = !any_src_reg;
            last_cell_next = (cnt_reg == CNTW'(n_run_reg - LCW'(1)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            load_cnt_reg  <= '0;
            any_src_reg   <= 1'b0;
            side_run_reg  <= SIDE_RESET;
            n_run_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            load_cnt_reg  <= load_cnt_next;
            any_src_reg   <= any_src_next;
            side_run_reg  <= side_run_next;
            n_run_reg     <= n_run_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        distance_reg  <= distance_next;
        no_source_reg <= no_source_next;
        last_cell_reg <= last_cell_next;
        rd_row_reg    <= row_reg;
        rd_col_reg    <= col_reg;
    end

    // source map memory
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_mem[load_cnt_reg[IDXW-1:0]] <= is_src;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_src_reg <= src_mem[cnt_reg[IDXW-1:0]];
    end

    assign inj_row   = row_reg;
    assign inj_col   = col_reg;
    assign bus_valid = rd_valid_reg && rd_src_reg;
    assign bus_row   = rd_row_reg;
    assign bus_col   = rd_col_reg;
    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign no_source = no_source_reg;
    assign last_cell = last_cell_reg;

endmodule
`default_nettype wire

FILE: src/grid_manhattan_distance_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_manhattan_distance_map
// City-block distance map of a square grid, built on a chain of cells.
// ----------------------------------------------------------------------------
// Cells of the grid come in one item per cycle while the block is in its
// load state, in row-major order; byte 48 marks a source. After the last of
// side*side items (side = grid_side, 0 read as 1, clipped to GRID_MAX) the
// block takes no input while it fills the chain of GRID_MAX*GRID_MAX cells
// and sweeps the source items through it, then emits one result item per
// cell, one per cycle while the sink is ready. Each source item has to pass
// through every cell of the chain. The next grid is taken as soon as the
// last result item sits in the output register. A grid without a source
// gives distance 0 and no_source set.
// ----------------------------------------------------------------------------
module grid_manhattan_distance_map import gmd_pkg::*; #(
    parameter int GRID_MAX = GRID_MAX_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    gmd_grid_if.sink                   grid,
    gmd_result_if.source               result
);

    localparam int CELLS = GRID_MAX * GRID_MAX;
    localparam int CW    = $clog2(GRID_MAX);

    logic [SIDE_W-1:0] grid_side_reg;
    logic              reg_idx;
    logic              cfg_write;

    gmd_cell_ctl_t     cell_ctl;
    logic [CW-1:0]     inj_row;
    logic [CW-1:0]     inj_col;
    logic              head_valid;
    logic [CW-1:0]     head_row;
    logic [CW-1:0]     head_col;

    logic [CW-1:0]     coord_row [CELLS];
    logic [CW-1:0]     coord_col [CELLS];
    logic              bus_valid [CELLS];
    logic [CW-1:0]     bus_row   [CELLS];
    logic [CW-1:0]     bus_col   [CELLS];
    logic [DIST_W-1:0] best      [CELLS];

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg <= SIDE_RESET;
        end
        else if (cfg_write && (reg_idx == REG_GRID_SIDE))
        begin
            grid_side_reg <= pwdata[SIDE_W-1:0];
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GRID_SIDE: prdata = APB_DATA_W'(grid_side_reg);
            default:       prdata = '0;
        endcase
    end

    gmd_seq #(
        .GRID_MAX (GRID_MAX)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid_side (grid_side_reg),
        .in_valid  (grid.valid),
        .in_ready  (grid.ready),
        .cell_char (grid.cell_char),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .distance  (result.distance),
        .no_source (result.no_source),
        .last_cell (result.last_cell),
        .cell_ctl  (cell_ctl),
        .inj_row   (inj_row),
        .inj_col   (inj_col),
        .bus_valid (head_valid),
        .bus_row   (head_row),
        .bus_col   (head_col),
        .tail_best (best[CELLS-1])
    );

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            gmd_cell #(
                .CW (CW)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctl           (cell_ctl),
                .coord_row_in  (inj_row),
                .coord_col_in  (inj_col),
                .coord_row_out (coord_row[k]),
                .coord_col_out (coord_col[k]),
                .bus_valid_in  (head_valid),
                .bus_row_in    (head_row),
                .bus_col_in    (head_col),
                .bus_valid_out (bus_valid[k]),
                .bus_row_out   (bus_row[k]),
                .bus_col_out   (bus_col[k]),
                .best_in       (FAR_AWAY),
                .best_out      (best[k])
            );
        end
        else
        begin : g_body
            gmd_cell #(
                .CW (CW)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctl           (cell_ctl),
                .coord_row_in  (coord_row[k-1]),
                .coord_col_in  (coord_col[k-1]),
                .coord_row_out (coord_row[k]),
                .coord_col_out (coord_col[k]),
                .bus_valid_in  (bus_valid[k-1]),
                .bus_row_in    (bus_row[k-1]),
                .bus_col_in    (bus_col[k-1]),
                .bus_valid_out (bus_valid[k]),
                .bus_row_out   (bus_row[k]),
                .bus_col_out   (bus_col[k]),
                .best_in       (best[k-1]),
                .best_out      (best[k])
            );
        end
    end

endmodule
`default_nettype wire

FILE: src/gmd_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmd_check
// Port-level checks of the grid distance map, bound to the top level.
// ----------------------------------------------------------------------------
module gmd_check import gmd_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              grid_valid,
    input wire logic              grid_ready,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire logic [DIST_W-1:0] distance,
    input wire logic              no_source,
    input wire logic              last_cell
);

    // stalled result item holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(distance) && $stable(no_source) && $stable(last_cell))
        else $error("result item changed while stalled");

    // no input while a grid is still being emitted
    a_no_load_mid_grid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_cell |-> !grid_ready)
        else $error("input taken while results pending");

    // empty grid gives zero distance, otherwise never the far marker
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (no_source && distance == '0) || (!no_source && distance <= DIST_MAX))
        else $error("distance out of range");

    // results of one grid follow back to back with the same no-source flag
    a_grid_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !last_cell |=> result_valid && $stable(no_source))
        else $error("no_source changed within a grid");

endmodule

bind grid_manhattan_distance_map gmd_check u_gmd_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .grid_valid   (grid.valid),
    .grid_ready   (grid.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .distance     (result.distance),
    .no_source    (result.no_source),
    .last_cell    (result.last_cell)
);
`default_nettype wire

FILE: tb/grid_manhattan_distance_map_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_manhattan_distance_map_tb
// Self-checking bench for the grid distance map block. Cells are streamed in
// bursts with random gaps while the result side stalls on shifting
// patterns. A built-in predictor tracks the side register, the source map and
// the load position, and it works out every cell's city-block distance when a
// grid closes. Directed grids cover single cells, grids without a source, a
// far corner source, an ignored register index and a side that shrinks while
// loading. Random grids then cover all side settings, side changes in the
// middle of a load and several source densities.
// ----------------------------------------------------------------------------
module grid_manhattan_distance_map_tb;
    import gmd_pkg::*;

    localparam int  CELLS_MAX    = GRID_MAX_DEF * GRID_MAX_DEF;
    localparam int  SETTLE_CYCLES = 3 * CELLS_MAX + 32;
    localparam int  RANDOM_CELLS = 350;
    localparam int  RUN_LIMIT_NS = 4_000_000;
    localparam int  PRINT_CAP    = 100;
    localparam logic REG_UNUSED  = ~REG_GRID_SIDE;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              no_source;
        logic              last_cell;
    } dist_item_t;

    typedef enum int {
        FILL_SPARSE,
        FILL_SINGLE,
        FILL_DENSE,
        FILL_EMPTY,
        FILL_RAW
    } fill_mode_t;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_QUARTER,
        SINK_MOSTLY
    } sink_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    gmd_grid_if   grid_ch ();
    gmd_result_if result_ch ();

    // predictor state
    logic [SIDE_W-1:0] side_reg;
    bit                src_bits [CELLS_MAX];
    logic [6:0]        cells_loaded;
    bit                grid_has_src;
    bit                grid_closed;
    dist_item_t        pending_distances [$];

    int         mismatch_count;
    int         cells_sent;
    int         burst_left;
    bit         cell_gaps_on;
    int         stall_tick;
    sink_mode_t stall_mode;

    grid_manhattan_distance_map u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .grid    (grid_ch),
        .result  (result_ch)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int side_in_force();
        int s;
        s = int'(side_reg);
        if (s < 1)
            s = 1;
        if (s > GRID_MAX_DEF)
            s = GRID_MAX_DEF;
        return s;
    endfunction

    // load one cell; when the grid closes, queue one distance per cell
    task automatic absorb_cell(input logic [CHAR_W-1:0] ch);
        int side;
        int n;
        int best;
        int d;
        dist_item_t item;
        side = side_in_force();
        n    = side * side;
        src_bits[cells_loaded[5:0]] = (ch == SOURCE_CHAR);
        if (ch == SOURCE_CHAR)
            grid_has_src = 1'b1;
        cells_loaded = cells_loaded + 7'd1;
        grid_closed  = (int'(cells_loaded) >= n);
        if (!grid_closed)
            return;
        for (int c = 0; c < n; c++)
        begin
            best = int'(FAR_AWAY);
            for (int s = 0; s < n; s++)
            begin
                if (src_bits[s])
                begin
                    d = ((c / side > s / side) ? c / side - s / side : s / side - c / side)
                      + ((c % side > s % side) ? c % side - s % side : s % side - c % side);
                    if (d < best)
                        best = d;
                end
            end
            item.distance  = grid_has_src ? best[DIST_W-1:0] : '0;
            item.no_source = !grid_has_src;
            item.last_cell = (c == n - 1);
            pending_distances.push_back(item);
        end
        cells_loaded = '0;
        grid_has_src = 1'b0;
    endtask

    task automatic send_cell(input logic [CHAR_W-1:0] ch);
        grid_ch.valid     <= 1'b1;
        grid_ch.cell_char <= ch;
        @(posedge clk);
        while (!grid_ch.ready)
            @(posedge clk);
        absorb_cell(ch);
        cells_sent++;
        if (cell_gaps_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                grid_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // stop the cell stream and let the block finish all pending work
    task automatic quiesce();
        grid_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_GRID_SIDE)
            side_reg = data[SIDE_W-1:0];
    endtask

    task automatic write_side(input logic [SIDE_W-1:0] side);
        logic [APB_DATA_W-1:0] data;
        data = $urandom();
        data[SIDE_W-1:0] = side;
        apb_write(REG_GRID_SIDE, data);
    endtask

    function automatic logic [CHAR_W-1:0] pick_cell(input fill_mode_t mode, input int pos,
                                                    input int src_pos);
        logic [CHAR_W-1:0] miss;
        if ($urandom_range(0, 1) == 0)
            miss = SOURCE_CHAR ^ (8'h01 << $urandom_range(0, 7));
        else
            miss = CHAR_W'($urandom_range(0, 255));
        if (miss == SOURCE_CHAR)
            miss = ~SOURCE_CHAR;
        case (mode)
            FILL_SPARSE: return ($urandom_range(0, 7) == 0) ? SOURCE_CHAR : miss;
            FILL_SINGLE: return (pos == src_pos) ? SOURCE_CHAR : miss;
            FILL_DENSE:  return ($urandom_range(0, 1) == 0) ? SOURCE_CHAR : miss;
            FILL_EMPTY:  return miss;
            default:     return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic check_result();
        dist_item_t want;
        if (pending_distances.size() == 0)
        begin
            report_mismatch("result item with nothing expected");
            return;
        end
        want = pending_distances.pop_front();
        if (result_ch.distance !== want.distance)
            report_mismatch($sformatf("distance got %0d want %0d",
                                      result_ch.distance, want.distance));
        if (result_ch.no_source !== want.no_source)
            report_mismatch($sformatf("no_source got %b want %b",
                                      result_ch.no_source, want.no_source));
        if (result_ch.last_cell !== want.last_cell)
            report_mismatch($sformatf("last_cell got %b want %b",
                                      result_ch.last_cell, want.last_cell));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                check_result();
            stall_tick++;
            if (stall_tick % 64 == 0)
                stall_mode = sink_mode_t'($urandom_range(0, 3));
            case (stall_mode)
                SINK_OPEN:    result_ch.ready <= 1'b1;
                SINK_COIN:    result_ch.ready <= ($urandom_range(0, 1) == 1);
                SINK_QUARTER: result_ch.ready <= (stall_tick % 4 == 0);
                default:      result_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // side 0 runs as 1; sources, zero bytes, all-ones and near misses
    task automatic test_single_cell_grids();
        quiesce();
        write_side(4'd0);
        send_cell(SOURCE_CHAR);
        send_cell(8'hFF);
        send_cell(8'h00);
        send_cell(SOURCE_CHAR | 8'h80);
    endtask

    task automatic test_sourceless_grid();
        quiesce();
        write_side(4'd2);
        send_cell(SOURCE_CHAR - 8'd1);
        send_cell(SOURCE_CHAR + 8'd1);
        send_cell(8'h70);
        send_cell(8'h10);
    endtask

    // unused register index must leave the side alone
    task automatic test_corner_source();
        quiesce();
        write_side(4'd3);
        apb_write(REG_UNUSED, 32'h0000_0001);
        for (int i = 0; i < 8; i++)
            send_cell(8'h01 << i);
        send_cell(SOURCE_CHAR);
    endtask

    // side shrinks so that side*side equals the loaded count: next cell closes the grid
    task automatic test_shrink_mid_load();
        quiesce();
        write_side(4'd3);
        send_cell(SOURCE_CHAR);
        send_cell(8'h41);
        send_cell(8'h41);
        send_cell(8'h41);
        quiesce();
        write_side(4'd2);
        send_cell(8'hC1);
    endtask

    task automatic test_random_grids();
        logic [SIDE_W-1:0] opening [4];
        int         start;
        int         phase;
        int         n;
        int         pos;
        int         src_pos;
        int         change_at;
        fill_mode_t mode;
        opening[0] = 4'd15;
        opening[1] = 4'd0;
        opening[2] = 4'd8;
        opening[3] = 4'd1;
        start = cells_sent;
        phase = 0;
        while (cells_sent - start < RANDOM_CELLS)
        begin
            if (phase < 4 || $urandom_range(0, 2) == 0)
            begin
                quiesce();
                if (phase < 4)
                    write_side(opening[phase]);
                else if ($urandom_range(0, 4) != 0)
                    write_side(SIDE_W'($urandom_range(1, 4)));
                else
                    write_side(SIDE_W'($urandom_range(0, 15)));
                if ($urandom_range(0, 5) == 0)
                    apb_write(REG_UNUSED, $urandom());
            end
            phase++;
            cell_gaps_on = ($urandom_range(0, 3) != 0);
            n         = side_in_force() * side_in_force();
            mode      = fill_mode_t'($urandom_range(0, 4));
            src_pos   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, n - 1);
            change_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : -1;
            pos = 0;
            grid_closed = 1'b0;
            while (!grid_closed)
            begin
                if (pos == change_at)
                begin
                    quiesce();
                    write_side(SIDE_W'($urandom_range(0, 15)));
                end
                send_cell(pick_cell(mode, pos, src_pos));
                pos++;
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        grid_ch.valid     = 1'b0;
        grid_ch.cell_char = '0;
        result_ch.ready   = 1'b0;
        side_reg          = SIDE_RESET;
        foreach (src_bits[i])
            src_bits[i] = 1'b0;
        cells_loaded      = '0;
        grid_has_src      = 1'b0;
        grid_closed       = 1'b0;
        mismatch_count    = 0;
        cells_sent        = 0;
        burst_left        = $urandom_range(1, 24);
        cell_gaps_on      = 1'b1;
        stall_tick        = 0;
        stall_mode        = SINK_OPEN;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_cell_grids();
        test_sourceless_grid();
        test_corner_source();
        test_shrink_mid_load();
        test_random_grids();

        quiesce();
        if (mismatch_count == 0)
            $display("** grid_manhattan_distance_map: PASSED **");
        else
            $display("** grid_manhattan_distance_map: FAILED **");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[%0t] timeout, %0d results still expected", $time,
                 pending_distances.size());
        $display("** grid_manhattan_distance_map: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
src/gmd_pkg.sv
src/gmd_ifs.sv
src/gmd_cell.sv
src/gmd_seq.sv
src/grid_manhattan_distance_map.sv
src/gmd_check.sv
tb/grid_manhattan_distance_map_tb.sv
